### src/cdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_pkg: shared types and constants for the calendar date counter
// Transaction structs, status codes, microcode word layout and the
// month length lookup used by the datapath.
// ----------------------------------------------------------------------------
package cdc_pkg;

    // Field widths
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int YEAR_W      = 12;
    localparam int DAY_COUNT_W = 10;
    localparam int STATUS_W    = 3;
    localparam int PC_W        = 3;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 12'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 12'd2100;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [DAY_W-1:0]   DAY_LEAP   = 5'd29;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_YEAR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    // Microprogram addresses
    localparam logic [PC_W-1:0] UA_IDLE     = 3'd0;
    localparam logic [PC_W-1:0] UA_DISPATCH = 3'd1;
    localparam logic [PC_W-1:0] UA_CHECK    = 3'd2;
    localparam logic [PC_W-1:0] UA_SET      = 3'd3;
    localparam logic [PC_W-1:0] UA_ADV_TEST = 3'd4;
    localparam logic [PC_W-1:0] UA_STEP     = 3'd5;
    localparam logic [PC_W-1:0] UA_DONE     = 3'd6;
    localparam logic [PC_W-1:0] UA_SPARE    = 3'd7;

    // Input transaction
    typedef struct packed {
        logic                   mode;
        logic [MONTH_W-1:0]     new_month;
        logic [DAY_W-1:0]       new_day;
        logic [YEAR_W-1:0]      new_year;
        logic [DAY_COUNT_W-1:0] day_count;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [MONTH_W-1:0]  cur_month;
        logic [DAY_W-1:0]    cur_day;
        logic [YEAR_W-1:0]   cur_year;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_CHECK = 3'd1,
        OP_SET   = 3'd2,
        OP_STEP  = 3'd3,
        OP_EMIT  = 3'd4
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        CND_ALWAYS = 3'd0,
        CND_START  = 3'd1,
        CND_MODE   = 3'd2,
        CND_BAD    = 3'd3,
        CND_ZERO   = 3'd4,
        CND_LAST   = 3'd5
    } t_cond;

    // One control word: take the jump when the condition holds,
    // otherwise stay (hold) or fall through to the next step
    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            hold;
    } t_uword;

    // Sequencer to datapath control
    typedef struct packed {
        logic load;
        t_op  op;
    } t_dp_ctrl;

    // Datapath to sequencer status
    typedef struct packed {
        logic mode;
        logic bad;
        logic zero;
        logic last;
    } t_dp_flags;

    // Month length; leap rule is exact for years 1900 to 2100
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] n;
        logic             leap;
        leap = (y[1:0] == 2'b00) && (y != YEAR_MIN) && (y != YEAR_MAX);
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = 5'd28;
            default:                                     n = 5'd0;
        endcase
        if (m == MONTH_FEB && leap) begin
            n = DAY_LEAP;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### src/cdc_ucode_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_ucode_rom: microprogram store
// Read-only table of control words, one per step of the sequencer.
// ----------------------------------------------------------------------------
module cdc_ucode_rom (
    input  wire logic [cdc_pkg::PC_W-1:0] i_addr,
    output cdc_pkg::t_uword               o_word
);

    // Look up the control word for the current step
    always_comb begin
        unique case (i_addr)
            cdc_pkg::UA_IDLE:     o_word = '{cdc_pkg::OP_NOP,   cdc_pkg::CND_START,
                                             cdc_pkg::UA_DISPATCH, 1'b1};
            cdc_pkg::UA_DISPATCH: o_word = '{cdc_pkg::OP_NOP,   cdc_pkg::CND_MODE,
                                             cdc_pkg::UA_ADV_TEST, 1'b0};
            cdc_pkg::UA_CHECK:    o_word = '{cdc_pkg::OP_CHECK, cdc_pkg::CND_BAD,
                                             cdc_pkg::UA_DONE, 1'b0};
            cdc_pkg::UA_SET:      o_word = '{cdc_pkg::OP_SET,   cdc_pkg::CND_ALWAYS,
                                             cdc_pkg::UA_DONE, 1'b0};
            cdc_pkg::UA_ADV_TEST: o_word = '{cdc_pkg::OP_NOP,   cdc_pkg::CND_ZERO,
                                             cdc_pkg::UA_DONE, 1'b0};
            cdc_pkg::UA_STEP:     o_word = '{cdc_pkg::OP_STEP,  cdc_pkg::CND_LAST,
                                             cdc_pkg::UA_DONE, 1'b1};
            cdc_pkg::UA_DONE:     o_word = '{cdc_pkg::OP_EMIT,  cdc_pkg::CND_ALWAYS,
                                             cdc_pkg::UA_IDLE, 1'b0};
            default:              o_word = '{cdc_pkg::OP_NOP,   cdc_pkg::CND_ALWAYS,
                                             cdc_pkg::UA_IDLE, 1'b0};
        endcase
    end

endmodule
`default_nettype wire

### src/cdc_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_sequencer: step counter and jump logic
// Walks the microprogram, evaluates jump conditions on datapath flags and
// issues one operation per cycle.
// ----------------------------------------------------------------------------
module cdc_sequencer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire cdc_pkg::t_dp_flags  i_flags,
    output cdc_pkg::t_dp_ctrl        o_ctrl,
    output logic                     o_busy
);

    logic [cdc_pkg::PC_W-1:0] r_pc;
    logic [cdc_pkg::PC_W-1:0] n_pc;
    cdc_pkg::t_uword          uword;
    logic                     taken;

    cdc_ucode_rom u_rom (
        .i_addr (r_pc),
        .o_word (uword)
    );

    // Select the jump condition
    always_comb begin
        unique case (uword.cond)
            cdc_pkg::CND_ALWAYS: taken = 1'b1;
            cdc_pkg::CND_START:  taken = i_start;
            cdc_pkg::CND_MODE:   taken = i_flags.mode;
            cdc_pkg::CND_BAD:    taken = i_flags.bad;
            cdc_pkg::CND_ZERO:   taken = i_flags.zero;
            cdc_pkg::CND_LAST:   taken = i_flags.last;
            default:             taken = 1'b1;
        endcase
    end

    // Jump, hold or fall through
    always_comb begin
        if (taken) begin
            n_pc = uword.target;
        end else if (uword.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = cdc_pkg::PC_W'(r_pc + 1'b1);
        end
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= cdc_pkg::UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_busy      = (r_pc != cdc_pkg::UA_IDLE);
    assign o_ctrl.load = i_start && !o_busy;
    assign o_ctrl.op   = uword.op;

endmodule
`default_nettype wire

### src/cdc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdc_datapath: date registers, set checks and day stepper
// Holds the stored date, the captured transaction, the remaining day count
// and the status, and performs the operation named by the control word.
// ----------------------------------------------------------------------------
module cdc_datapath #(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cdc_pkg::t_dp_ctrl i_ctrl,
    input  wire cdc_pkg::t_in_item i_item,
    output cdc_pkg::t_dp_flags     o_flags,
    output cdc_pkg::t_out_item     o_result
);

    localparam int USE_W = (COUNT_WIDTH < cdc_pkg::DAY_COUNT_W) ?
                           COUNT_WIDTH : cdc_pkg::DAY_COUNT_W;

    logic [cdc_pkg::MONTH_W-1:0]  r_month;
    logic [cdc_pkg::DAY_W-1:0]    r_day;
    logic [cdc_pkg::YEAR_W-1:0]   r_year;
    logic [COUNT_WIDTH-1:0]       r_count;
    logic [cdc_pkg::STATUS_W-1:0] r_status;
    cdc_pkg::t_in_item            r_item;

    logic [cdc_pkg::STATUS_W-1:0] check_code;
    logic [cdc_pkg::DAY_W-1:0]    new_len;
    logic [cdc_pkg::DAY_W-1:0]    cur_len;
    logic                         at_end;

    // Validate the requested date: month, then year, then day
    always_comb begin
        new_len = cdc_pkg::days_in(r_item.new_month, r_item.new_year);
        priority if (r_item.new_month == '0 || r_item.new_month > cdc_pkg::MONTH_LAST) begin
            check_code = cdc_pkg::ST_BAD_MONTH;
        end else if (r_item.new_year < cdc_pkg::YEAR_MIN ||
                     r_item.new_year > cdc_pkg::YEAR_MAX) begin
            check_code = cdc_pkg::ST_BAD_YEAR;
        end else if (r_item.new_day == '0 || r_item.new_day > new_len) begin
            check_code = cdc_pkg::ST_BAD_DAY;
        end else begin
            check_code = cdc_pkg::ST_OK;
        end
    end

    // Last day the calendar can reach
    assign cur_len = cdc_pkg::days_in(r_month, r_year);
    assign at_end  = (r_day >= cur_len) && (r_month >= cdc_pkg::MONTH_LAST) &&
                     (r_year >= cdc_pkg::YEAR_MAX);

    // Flags for the sequencer
    assign o_flags.mode = r_item.mode;
    assign o_flags.bad  = (check_code != cdc_pkg::ST_OK);
    assign o_flags.zero = (r_count == '0);
    assign o_flags.last = at_end || (r_count == COUNT_WIDTH'(1));

    // Capture the transaction, record the check status and count down the remaining days
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_item   <= i_item;
            r_count  <= COUNT_WIDTH'(i_item.day_count[USE_W-1:0]);
            r_status <= cdc_pkg::ST_OK;
        end else if (i_ctrl.op == cdc_pkg::OP_CHECK) begin
            r_status <= check_code;
        end else if (i_ctrl.op == cdc_pkg::OP_STEP) begin
            if (at_end) begin
                r_status <= cdc_pkg::ST_OVERFLOW;
            end else begin
                r_count <= COUNT_WIDTH'(r_count - 1'b1);
            end
        end
    end

    // Update the stored date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= 5'd1;
            r_month <= 4'd1;
            r_year  <= cdc_pkg::YEAR_MIN;
        end else if (!i_ctrl.load) begin
            unique case (i_ctrl.op)
                cdc_pkg::OP_SET: begin
                    r_day   <= r_item.new_day;
                    r_month <= r_item.new_month;
                    r_year  <= r_item.new_year;
                end
                cdc_pkg::OP_STEP: begin
                    if (r_day < cur_len) begin
                        r_day <= cdc_pkg::DAY_W'(r_day + 1'b1);
                    end else if (r_month < cdc_pkg::MONTH_LAST) begin
                        r_month <= cdc_pkg::MONTH_W'(r_month + 1'b1);
                        r_day   <= 5'd1;
                    end else if (!at_end) begin
                        r_year  <= cdc_pkg::YEAR_W'(r_year + 1'b1);
                        r_month <= 4'd1;
                        r_day   <= 5'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result.cur_month = r_month;
    assign o_result.cur_day   = r_day;
    assign o_result.cur_year  = r_year;
    assign o_result.status    = r_status;

endmodule
`default_nettype wire

### src/calendar_date_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_counter: Gregorian date keeper, 1900-01-01 to 2100-12-31
// Sets a checked date or advances the stored date by a count of days,
// under control of a small microprogram.
// ----------------------------------------------------------------------------
//  channel   | ports                     | handshake
//  ----------+---------------------------+----------------------------------
//  command   | start, busy, i_item       | taken when start high, busy low
//  result    | o_done, o_result          | one-cycle strobe, cannot stall
//
//  A valid set passes the check step and the store step before o_done
//  strobes; a rejected set goes from the check step straight to the strobe.
//  An advance of zero days strobes without stepping; otherwise the day
//  stepper moves one day per cycle until the count is spent. An advance
//  that reaches 2100-12-31 with days left over strobes and holds that date.
//  busy drops the cycle after the strobe; reset gives 1900-01-01.
// ----------------------------------------------------------------------------
module calendar_date_counter #(
    parameter int COUNT_WIDTH = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cdc_pkg::t_in_item i_item,
    output logic                   o_done,
    output cdc_pkg::t_out_item     o_result
);

    cdc_pkg::t_dp_ctrl  ctrl;
    cdc_pkg::t_dp_flags flags;

    cdc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    cdc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_item),
        .o_flags  (flags),
        .o_result (o_result)
    );

    // Strobe the result on the emit step
    assign o_done = (ctrl.op == cdc_pkg::OP_EMIT);

    // A result only comes out of a running transaction
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // The sequencer returns to idle right after the result
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy && !o_done)
        else $error("sequencer did not return to idle after result");

    // A taken transaction makes the block busy
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transaction taken but block not busy");

    // Overflow only ever holds the last date
    a_ovf_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == cdc_pkg::ST_OVERFLOW |->
            o_result.cur_year == cdc_pkg::YEAR_MAX &&
            o_result.cur_month == cdc_pkg::MONTH_LAST && o_result.cur_day == 5'd31)
        else $error("overflow reported away from the last date");

    // The stored date keeps a legal month and a non-zero day
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.cur_month != '0 && o_result.cur_month <= cdc_pkg::MONTH_LAST &&
            o_result.cur_day != '0)
        else $error("stored date out of range");

endmodule
`default_nettype wire

### tb/sv/calendar_date_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_counter_tb: self-checking bench for the calendar date counter
// Sends set and advance transactions with random idle bursts, keeps its own
// copy of the stored date to predict every result, and compares each strobed
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_date_counter_tb;

    localparam int RANDOM_CMDS = 555;
    localparam int TAIL_CMDS   = 60;

    // One command waiting to be sent, with the idle burst that follows it
    typedef struct packed {
        cdc_pkg::t_in_item cmd;
        logic              drain;
        logic [3:0]        gap;
    } t_queued_cmd;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    cdc_pkg::t_in_item  i_item  = '0;
    logic               busy;
    logic               o_done;
    cdc_pkg::t_out_item o_result;

    t_queued_cmd        pending_cmds[$];
    cdc_pkg::t_out_item expected_dates[$];

    // Date as the bench believes the block holds it
    logic [cdc_pkg::MONTH_W-1:0] cal_month = 4'd1;
    logic [cdc_pkg::DAY_W-1:0]   cal_day   = 5'd1;
    logic [cdc_pkg::YEAR_W-1:0]  cal_year  = cdc_pkg::YEAR_MIN;

    int unsigned mismatches   = 0;
    int unsigned cmds_issued  = 0;
    int unsigned results_seen = 0;
    int unsigned gap_left     = 0;
    int unsigned cur_gap      = 0;

    calendar_date_counter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit leap_year(input int y);
        if (y % 4 != 0) return 1'b0;
        if (y % 100 != 0) return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Apply one command to the bench date and build the result it should give
    task automatic predict_date(input cdc_pkg::t_in_item cmd,
                                output cdc_pkg::t_out_item res);
        int unsigned left;
        res.status = cdc_pkg::ST_OK;
        if (cmd.mode == 1'b0) begin
            if (cmd.new_month < 1 || cmd.new_month > cdc_pkg::MONTH_LAST) begin
                res.status = cdc_pkg::ST_BAD_MONTH;
            end else if (cmd.new_year < cdc_pkg::YEAR_MIN ||
                         cmd.new_year > cdc_pkg::YEAR_MAX) begin
                res.status = cdc_pkg::ST_BAD_YEAR;
            end else if (cmd.new_day < 1 ||
                         cmd.new_day > month_days(cmd.new_month, cmd.new_year)) begin
                res.status = cdc_pkg::ST_BAD_DAY;
            end else begin
                cal_month = cmd.new_month;
                cal_day   = cmd.new_day;
                cal_year  = cmd.new_year;
            end
        end else begin
            // all count bits are in use at the default count width
            left = cmd.day_count;
            while (left > 0 && res.status == cdc_pkg::ST_OK) begin
                if (cal_day < month_days(cal_month, cal_year)) begin
                    cal_day = cal_day + 1'b1;
                end else if (cal_month < cdc_pkg::MONTH_LAST) begin
                    cal_month = cal_month + 1'b1;
                    cal_day   = 5'd1;
                end else if (cal_year < cdc_pkg::YEAR_MAX) begin
                    cal_year  = cal_year + 1'b1;
                    cal_month = 4'd1;
                    cal_day   = 5'd1;
                end else begin
                    res.status = cdc_pkg::ST_OVERFLOW;
                end
                left--;
            end
        end
        res.cur_month = cal_month;
        res.cur_day   = cal_day;
        res.cur_year  = cal_year;
    endtask

    // Set command; the ignored count carries noise
    function automatic cdc_pkg::t_in_item set_cmd(input int m, input int d, input int y);
        cdc_pkg::t_in_item c;
        c.mode      = 1'b0;
        c.new_month = cdc_pkg::MONTH_W'(m);
        c.new_day   = cdc_pkg::DAY_W'(d);
        c.new_year  = cdc_pkg::YEAR_W'(y);
        c.day_count = cdc_pkg::DAY_COUNT_W'($urandom);
        return c;
    endfunction

    // Advance command; the ignored date fields carry noise
    function automatic cdc_pkg::t_in_item adv_cmd(input int n);
        cdc_pkg::t_in_item c;
        c.mode      = 1'b1;
        c.new_month = cdc_pkg::MONTH_W'($urandom);
        c.new_day   = cdc_pkg::DAY_W'($urandom);
        c.new_year  = cdc_pkg::YEAR_W'($urandom);
        c.day_count = cdc_pkg::DAY_COUNT_W'(n);
        return c;
    endfunction

    task automatic queue_cmd(input cdc_pkg::t_in_item c, input bit drain, input int gap);
        t_queued_cmd q;
        q.cmd   = c;
        q.drain = drain;
        q.gap   = 4'(gap);
        pending_cmds.push_back(q);
    endtask

    // Driver: present queued commands, predict each one as it is taken
    always @(posedge i_clk) begin : drive_proc
        logic               accepted;
        logic               start_nxt;
        cdc_pkg::t_in_item  item_nxt;
        cdc_pkg::t_out_item want;
        t_queued_cmd        q;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            accepted  = start && !busy;
            start_nxt = start;
            item_nxt  = i_item;
            if (o_done) begin
                results_seen++;
            end
            if (accepted) begin
                predict_date(i_item, want);
                expected_dates.push_back(want);
                cmds_issued++;
                gap_left  = cur_gap;
                start_nxt = 1'b0;
            end
            // hold off for the idle burst, or until drained when asked
            if (!start_nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0 &&
                             (!pending_cmds[0].drain || cmds_issued == results_seen)) begin
                    q         = pending_cmds.pop_front();
                    start_nxt = 1'b1;
                    item_nxt  = q.cmd;
                    cur_gap   = q.gap;
                end
            end
            start  <= start_nxt;
            i_item <= item_nxt;
        end
    end

    // Monitor: take each strobed result and compare it with the oldest prediction
    always @(posedge i_clk) begin : check_proc
        cdc_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            if (expected_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with none expected: %0d-%0d-%0d status %0d",
                             $realtime, o_result.cur_year, o_result.cur_month,
                             o_result.cur_day, o_result.status);
                end
            end else begin
                want = expected_dates.pop_front();
                if (o_result.cur_month !== want.cur_month ||
                    o_result.cur_day !== want.cur_day ||
                    o_result.cur_year !== want.cur_year ||
                    o_result.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected %0d-%0d-%0d status %0d, %s",
                                 $realtime, want.cur_year, want.cur_month, want.cur_day,
                                 want.status,
                                 $sformatf("got %0d-%0d-%0d status %0d",
                                           o_result.cur_year, o_result.cur_month,
                                           o_result.cur_day, o_result.status));
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : stim_proc
        cdc_pkg::t_in_item c;
        int                idx;
        int                pick;
        int                m;
        int                d;
        int                y;
        int                md;
        int                gap;
        bit                gaps_on;

        // directed: check order, month lengths, leap rule, roll-overs, overflow
        queue_cmd(adv_cmd(0), 1'b0, 0);
        queue_cmd(set_cmd(0, 15, 2000), 1'b0, $urandom_range(0, 3));
        queue_cmd(set_cmd(13, 10, 1899), 1'b0, 0);
        queue_cmd(set_cmd(15, 0, 4095), 1'b0, $urandom_range(0, 15));
        queue_cmd(set_cmd(6, 0, 1899), 1'b0, 0);
        queue_cmd(set_cmd(6, 10, 2101), 1'b0, 0);
        queue_cmd(set_cmd(1, 1, 0), 1'b0, $urandom_range(0, 5));
        queue_cmd(set_cmd(4, 31, 2000), 1'b0, 0);
        queue_cmd(set_cmd(2, 29, 1900), 1'b0, 0);
        queue_cmd(set_cmd(2, 29, 2100), 1'b0, 0);
        queue_cmd(set_cmd(2, 29, 2000), 1'b0, 0);
        queue_cmd(set_cmd(1, 0, 1950), 1'b0, 0);
        queue_cmd(set_cmd(2, 28, 1900), 1'b0, 0);
        queue_cmd(adv_cmd(1), 1'b0, $urandom_range(0, 15));
        queue_cmd(set_cmd(12, 31, 2099), 1'b0, 0);
        queue_cmd(adv_cmd(1), 1'b0, 0);
        queue_cmd(set_cmd(2, 28, 2024), 1'b0, 0);
        queue_cmd(adv_cmd(2), 1'b0, 0);
        queue_cmd(set_cmd(12, 31, 2100), 1'b1, 0);
        queue_cmd(adv_cmd(1), 1'b0, 0);
        queue_cmd(adv_cmd(0), 1'b0, 0);
        queue_cmd(set_cmd(12, 20, 2100), 1'b0, 0);
        queue_cmd(adv_cmd(1023), 1'b0, 0);
        queue_cmd(set_cmd(1, 1, 1900), 1'b1, 0);
        queue_cmd(adv_cmd(1023), 1'b0, $urandom_range(1, 15));

        // random: mostly legal dates and short advances, some noise and long runs
        for (idx = 0; idx < RANDOM_CMDS; idx++) begin
            gaps_on = (idx < RANDOM_CMDS - TAIL_CMDS) && ((idx / 48) % 3 != 2);
            gap     = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
            pick    = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 9) == 0) begin
                    y = $urandom_range(2098, 2100);
                    m = 12;
                end else begin
                    y = $urandom_range(cdc_pkg::YEAR_MIN, cdc_pkg::YEAR_MAX);
                    m = $urandom_range(1, 12);
                end
                d = $urandom_range(1, month_days(m, y));
                c = set_cmd(m, d, y);
            end else if (pick < 45) begin
                // raw noise, nearly always rejected
                c      = set_cmd($urandom, $urandom, $urandom);
                c.mode = 1'b0;
            end else if (pick < 50) begin
                // legal month and year, day just past the month end or zero
                y  = $urandom_range(cdc_pkg::YEAR_MIN, cdc_pkg::YEAR_MAX);
                m  = $urandom_range(1, 12);
                md = month_days(m, y);
                d  = (md == 31 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(md + 1, 31);
                c  = set_cmd(m, d, y);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    c = adv_cmd($urandom_range(0, 40));
                end else if (pick < 9) begin
                    c = adv_cmd($urandom_range(0, 400));
                end else begin
                    c = adv_cmd($urandom_range(0, 1023));
                end
            end
            queue_cmd(c, $urandom_range(0, 39) == 0, gap);
        end

        // release reset once the commands are queued
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything sent, every result back, then a short settle
        do @(negedge i_clk); while (pending_cmds.size() > 0 || start);
        do @(negedge i_clk); while (expected_dates.size() > 0);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog_proc
        #25_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
